>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TMSS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tmss assertion failed");

// Checked on every rising edge, reset included.
`define TMSS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("tmss assertion failed");

`endif

>>> design/tmss_pkg.sv
// ----------------------------------------------------------------------------
// tmss_pkg
// Widths, constants, register codes and shared structs of the trimmed mean
// sensor scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmss_pkg;

   // Ring geometry.
   localparam int RING_DEPTH = 6;
   localparam int SAMPLE_W   = 12;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);

   // Division by the number of samples left after trimming, done as a
   // reciprocal multiply followed by one correction step.
   localparam int TRIM_DIV   = RING_DEPTH - 2;
   localparam int RECIP_W    = 2 * SUM_W;
   localparam int RECIP      = (2 ** SUM_W) / TRIM_DIV;

   // Millivolt conversion.
   localparam int MV_W       = 13;
   localparam int MV_SCALE   = 5000;
   localparam int MV_SHIFT   = 12;
   localparam int MVP_W      = SAMPLE_W + MV_W;

   // Level mapping.
   localparam int GAIN_W     = 16;
   localparam int OFFSET_W   = 21;
   localparam int LEVEL_W    = 16;
   localparam int Q_SHIFT    = 8;
   localparam int PROD_W     = GAIN_W + MV_W + 1;
   localparam int LVL_SUM_W  = PROD_W - Q_SHIFT + 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;

   localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = -16'sd4352;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 21'sd4539;
   localparam logic [LEVEL_W-1:0]         MAX_RESET    = 16'd3000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN   = 2'd0,
      CSR_OFFSET = 2'd1,
      CSR_MAX    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]   gain;
      logic signed [OFFSET_W-1:0] offset;
      logic [LEVEL_W-1:0]         level_max;
   } cfg_type;

   typedef struct packed {
      logic                done;
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
   } ring_stats_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] filtered_adc;
      logic [MV_W-1:0]     millivolts;
      logic [LEVEL_W-1:0]  level;
   } scale_result_type;

endpackage

>>> design/tmss_ram.sv
// ----------------------------------------------------------------------------
// tmss_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmss_ram #(
   parameter int DEPTH  = 6,
   parameter int WIDTH  = 12,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tmss_ring.sv
// ----------------------------------------------------------------------------
// tmss_ring
// Sample ring: writes the new sample, then sweeps the memory to form the
// sum, minimum and maximum of all entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmss_ring import tmss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] sample,
   output ring_stats_type      stats
);

   typedef enum logic [1:0] {
      R_IDLE,
      R_READ,
      R_DRAIN
   } ring_state_type;

   ring_state_type      state_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   rd_cnt_ff;
   logic [RING_DEPTH-1:0] valid_ff;
   logic                done_ff;
   logic                dv_ff;
   logic                first_ff;
   logic                rd_vld_ff;

   logic                rd_en;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] entry;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;
   logic [SAMPLE_W-1:0] hi_ff, hi_in;

   assign rd_en = (state_ff == R_READ);

   tmss_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (start && (state_ff == R_IDLE)),
      .wr_addr (slot_ff),
      .wr_data (sample),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= R_IDLE;
         slot_ff   <= '0;
         rd_cnt_ff <= '0;
         valid_ff  <= '0;
         done_ff   <= 1'b0;
         dv_ff     <= 1'b0;
         first_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         dv_ff   <= rd_en;
         unique case (state_ff)
            R_IDLE: begin
               if (start) begin
                  valid_ff[slot_ff] <= 1'b1;
                  slot_ff   <= (slot_ff == SLOT_W'(RING_DEPTH - 1)) ?
                               '0 : slot_ff + 1'b1;
                  rd_cnt_ff <= '0;
                  state_ff  <= R_READ;
               end
            end
            R_READ: begin
               // Entries never written since reset read as zero.
               rd_vld_ff <= valid_ff[rd_cnt_ff];
               first_ff  <= (rd_cnt_ff == '0);
               if (rd_cnt_ff == SLOT_W'(RING_DEPTH - 1)) begin
                  state_ff <= R_DRAIN;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
            end
            R_DRAIN: begin
               done_ff  <= 1'b1;
               state_ff <= R_IDLE;
            end
            default: begin
               state_ff <= R_IDLE;
            end
         endcase
      end
   end

   assign entry = rd_vld_ff ? rd_data : '0;

   always_comb begin
      if (first_ff) begin
         sum_in = SUM_W'(entry);
         lo_in  = entry;
         hi_in  = entry;
      end else begin
         sum_in = sum_ff + SUM_W'(entry);
         lo_in  = (entry < lo_ff) ? entry : lo_ff;
         hi_in  = (entry > hi_ff) ? entry : hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ff) begin
         sum_ff <= sum_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
      end
   end

   assign stats.done = done_ff;
   assign stats.sum  = sum_ff;
   assign stats.lo   = lo_ff;
   assign stats.hi   = hi_ff;

endmodule

>>> design/tmss_scale.sv
// ----------------------------------------------------------------------------
// tmss_scale
// Arithmetic sequencer: trimmed mean, millivolt conversion and clamped
// linear mapping to the sensor level, one operation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmss_scale import tmss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ring_stats_type   stats,
   input  cfg_type          cfg,
   output scale_result_type result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECIP,
      S_FIX,
      S_MV,
      S_MUL,
      S_SUM,
      S_CLAMP
   } scale_state_type;

   scale_state_type              state_ff;
   logic                         done_ff;

   logic [SUM_W-1:0]             trimmed_ff, trimmed_in;
   logic [SAMPLE_W-1:0]          quot_ff, quot_in;
   logic [SAMPLE_W-1:0]          mean_ff, mean_in;
   logic [MV_W-1:0]              mv_ff, mv_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [LVL_SUM_W-1:0]  lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]           level_ff, level_in;

   logic [RECIP_W-1:0]           recip_prod;
   logic [SUM_W-1:0]             rem;
   logic [MVP_W-1:0]             mv_prod;
   logic signed [PROD_W-1:0]     prod_shift;
   logic signed [LVL_SUM_W-1:0]  max_ext;

   always_comb begin
      trimmed_in = stats.sum - SUM_W'(stats.lo) - SUM_W'(stats.hi);

      // The reciprocal is rounded down, so the estimate is at most one low.
      recip_prod = RECIP_W'(trimmed_ff) * RECIP_W'(RECIP);
      quot_in    = recip_prod[SUM_W +: SAMPLE_W];

      rem     = trimmed_ff - SUM_W'(quot_ff) * SUM_W'(TRIM_DIV);
      mean_in = (rem >= SUM_W'(TRIM_DIV)) ? quot_ff + 1'b1 : quot_ff;

      mv_prod = MVP_W'(mean_ff) * MVP_W'(MV_SCALE);
      mv_in   = mv_prod[MV_SHIFT +: MV_W];

      prod_in = PROD_W'(cfg.gain) * PROD_W'($signed({1'b0, mv_ff}));

      // Arithmetic shift rounds towards minus infinity.
      prod_shift = prod_ff >>> Q_SHIFT;
      lvl_in     = LVL_SUM_W'(prod_shift) + LVL_SUM_W'(cfg.offset);

      max_ext = $signed(LVL_SUM_W'(cfg.level_max));
      if (lvl_ff < 0) begin
         level_in = '0;
      end else if (lvl_ff > max_ext) begin
         level_in = cfg.level_max;
      end else begin
         level_in = lvl_ff[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (stats.done) begin
                  state_ff <= S_RECIP;
               end
            end
            S_RECIP: state_ff <= S_FIX;
            S_FIX:   state_ff <= S_MV;
            S_MV:    state_ff <= S_MUL;
            S_MUL:   state_ff <= S_SUM;
            S_SUM:   state_ff <= S_CLAMP;
            S_CLAMP: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (stats.done) begin
               trimmed_ff <= trimmed_in;
            end
         end
         S_RECIP: quot_ff  <= quot_in;
         S_FIX:   mean_ff  <= mean_in;
         S_MV:    mv_ff    <= mv_in;
         S_MUL:   prod_ff  <= prod_in;
         S_SUM:   lvl_ff   <= lvl_in;
         S_CLAMP: level_ff <= level_in;
         default: ;
      endcase
   end

   assign result.done         = done_ff;
   assign result.filtered_adc = mean_ff;
   assign result.millivolts   = mv_ff;
   assign result.level        = level_ff;

endmodule

>>> design/trimmed_mean_sensor_scaler.sv
// ----------------------------------------------------------------------------
// trimmed_mean_sensor_scaler
// Keeps a ring of recent ADC samples and reports their trimmed mean, the
// mean in millivolts and a clamped linear sensor level for every sample.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | req_sample
//   rsp     | out       | rsp_valid / rsp_stall | rsp_filtered_adc, rsp_millivolts,
//           |           |                       | rsp_level
//   csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// After its request word is accepted, a result word passes these steps: the
// sample is written at the accepting edge, then come RING_DEPTH reads, the
// registered read data, seven sequencer steps and one output load. A new word
// is taken only once the last result is loaded; req_stall is high while a word is in flight,
// and a stalled result holds the block only once the next result is ready.
// Reset is synchronous; per-entry valid bits make the ring read as all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trimmed_mean_sensor_scaler import tmss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_W-1:0]    rsp_filtered_adc,
   output logic [MV_W-1:0]        rsp_millivolts,
   output logic [LEVEL_W-1:0]     rsp_level,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      T_IDLE,
      T_WORK,
      T_DELIVER
   } top_state_type;

   top_state_type       state_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_adc_ff;
   logic [MV_W-1:0]     rsp_mv_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   cfg_type             cfg_ff;

   logic                accept;
   logic                rsp_free;
   logic                load;
   ring_stats_type      stats;
   scale_result_type    result;

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = rsp_free &&
                      (((state_ff == T_WORK) && result.done) || (state_ff == T_DELIVER));

   tmss_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .sample (req_sample),
      .stats  (stats)
   );

   tmss_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .stats  (stats),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain      <= GAIN_RESET;
         cfg_ff.offset    <= OFFSET_RESET;
         cfg_ff.level_max <= MAX_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN:   cfg_ff.gain      <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_OFFSET: cfg_ff.offset    <= $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_MAX:    cfg_ff.level_max <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  state_ff <= T_WORK;
               end
            end
            T_WORK: begin
               if (result.done) begin
                  state_ff <= load ? T_IDLE : T_DELIVER;
               end
            end
            T_DELIVER: begin
               if (load) begin
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   // The sequencer holds its results until the next word starts, so the
   // output word can be loaded late without a copy.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_adc_ff   <= result.filtered_adc;
         rsp_mv_ff    <= result.millivolts;
         rsp_level_ff <= result.level;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_adc = rsp_adc_ff;
   assign rsp_millivolts   = rsp_mv_ff;
   assign rsp_level        = rsp_level_ff;

endmodule

>>> design/tmss_checker.sv
// ----------------------------------------------------------------------------
// tmss_checker
// Port-level checks of the trimmed mean sensor scaler, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_filtered_adc,
   input logic [12:0] rsp_millivolts,
   input logic [15:0] rsp_level
);

   logic [40:0] rsp_word;
   logic [24:0] mv_product;

   assign rsp_word   = {rsp_filtered_adc, rsp_millivolts, rsp_level};
   assign mv_product = 25'(rsp_filtered_adc) * 25'd5000;

   // A word waiting on the output stays put until it is taken.
   `TMSS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   `TMSS_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_word))

   // Only one word is in flight: acceptance closes the input at once.
   `TMSS_ASSERT(a_one_in_flight, req_valid && !req_stall |=> req_stall)

   // The millivolt field always matches the mean reported with it.
   `TMSS_ASSERT(a_mv_matches, rsp_valid |-> rsp_millivolts == mv_product[24:12])

   // Reset empties the output register.
   `TMSS_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)

endmodule

bind trimmed_mean_sensor_scaler tmss_checker u_tmss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_filtered_adc (rsp_filtered_adc),
   .rsp_millivolts   (rsp_millivolts),
   .rsp_level        (rsp_level)
);
